// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/cfb_pkg.sv =====
// Package for the circular FIFO: defaults, command codes and the status struct.
`default_nettype none

package cfb_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 8;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    // Status of one operation, produced by the controller when the word is taken.
    typedef struct packed {
        logic status;
        logic is_empty;
        logic is_full;
        logic rd_hit;
    } t_flags;

endpackage

`default_nettype wire

// ===== rtl/cfb_mem.sv =====
// Storage array of the FIFO with one write port and one registered read port.
`default_nettype none

module cfb_mem
    import cfb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output      logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled result keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/cfb_ctrl.sv =====
// Position, count and capacity control of the FIFO.
`default_nettype none

`include "assert_macros.svh"

module cfb_ctrl
    import cfb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire t_cmd          i_cmd,
    input  wire logic          i_cfg_we,
    input  wire logic [CW-1:0] i_cfg_wdata,
    output      logic          o_mem_we,
    output      logic [AW-1:0] o_mem_waddr,
    output      logic          o_mem_re,
    output      logic [AW-1:0] o_mem_raddr,
    output      t_flags        o_flags,
    output      logic [CW-1:0] o_occ
);

    localparam logic [CW-1:0] CapMax = CW'(DEPTH);
    localparam logic [CW-1:0] CapMin = CW'(1);

    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;

    logic [CW-1:0] w_cap;
    logic [CW-1:0] w_wp_inc;
    logic [CW-1:0] w_rp_inc;
    logic          w_full;
    logic          w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CapMax;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // A capacity of zero acts as one, any value above the storage depth as the depth.
    assign w_cap = (r_cap == '0) ? CapMin : ((r_cap > CapMax) ? CapMax : r_cap);

    assign w_wp_inc = CW'(r_wp) + CapMin;
    assign w_rp_inc = CW'(r_rp) + CapMin;
    assign w_full   = (r_count >= w_cap);
    assign w_empty  = (r_count == '0);

    always_comb begin
        n_wp            = r_wp;
        n_rp            = r_rp;
        n_count         = r_count;
        o_mem_we        = 1'b0;
        o_mem_re        = 1'b0;
        o_flags.status  = 1'b0;
        o_flags.rd_hit  = 1'b0;
        case (i_cmd)
            CMD_PUSH: begin
                if (w_full) begin
                    o_flags.status = 1'b1;
                end else begin
                    o_mem_we = i_acc;
                    if (i_acc) begin
                        n_wp    = (w_wp_inc >= w_cap) ? '0 : w_wp_inc[AW-1:0];
                        n_count = r_count + CapMin;
                    end
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (w_empty) begin
                    o_flags.status = 1'b1;
                end else begin
                    o_mem_re       = i_acc;
                    o_flags.rd_hit = 1'b1;
                    if (i_acc && (i_cmd == CMD_POP)) begin
                        n_rp    = (w_rp_inc >= w_cap) ? '0 : w_rp_inc[AW-1:0];
                        n_count = r_count - CapMin;
                    end
                end
            end
            CMD_FLUSH: begin
                if (i_acc) begin
                    n_wp    = r_rp;
                    n_count = '0;
                end
            end
            default: begin
                n_wp = r_wp;
            end
        endcase
        o_flags.is_empty = (n_count == '0);
        o_flags.is_full  = (n_count >= w_cap);
    end

    assign o_mem_waddr = r_wp;
    assign o_mem_raddr = r_rp;
    assign o_occ       = n_count;

    `ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CapMax)
    `ASSERT_RST(a_refused_push_keeps, i_clk, i_rst_n,
        (i_acc && (i_cmd == CMD_PUSH) && w_full) |=> $stable(r_count) && $stable(r_wp))
    `ASSERT_RST(a_flush_empties, i_clk, i_rst_n,
        (i_acc && (i_cmd == CMD_FLUSH)) |=> (r_count == '0) && (r_wp == r_rp))

endmodule

`default_nettype wire

// ===== rtl/circular_fifo_buffer.sv =====
// Top level of the circular FIFO: command port, result register and storage.
//
//   channel   direction  handshake            payload
//   command   in         i_valid / o_stall    i_cmd, i_data_in
//   result    out        o_valid / i_stall    o_data_out, o_status, o_is_empty,
//                                             o_is_full, o_occupancy
//   config    in         i_cfg_we             i_cfg_wdata (capacity)
//
// Positions and count are updated at the edge that accepts a command word, and
// the storage read issued at that edge loads the oldest byte into the storage
// read register as the flags enter the result register. With the result side
// free, one word is accepted every cycle; the single result register sets this.
// Reset is synchronous and active low; it empties the FIFO and sets the
// capacity to the full depth, but leaves the storage contents untouched.
// A stalled result holds its word and stalls the command side in turn.
`default_nettype none

`include "assert_macros.svh"

module circular_fifo_buffer
    import cfb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command channel.
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_data_in,
    // Result channel.
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic [DATA_WIDTH-1:0] o_data_out,
    output      logic                  o_status,
    output      logic                  o_is_empty,
    output      logic                  o_is_full,
    output      logic [CW-1:0]         o_occupancy,
    // Capacity register.
    input  wire logic                  i_cfg_we,
    input  wire logic [CW-1:0]         i_cfg_wdata
);

    logic                  w_acc;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic                  w_mem_re;
    logic [AW-1:0]         w_mem_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    t_flags                w_flags;
    logic [CW-1:0]         w_occ;

    logic                  r_out_valid, n_out_valid;
    t_flags                r_flags;
    logic [CW-1:0]         r_occ;

    // A new word can enter whenever the result register is empty or being taken.
    assign o_stall = r_out_valid && i_stall;
    assign w_acc   = i_valid && !o_stall;

    cfb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_cmd       (t_cmd'(i_cmd)),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .o_flags     (w_flags),
        .o_occ       (w_occ)
    );

    cfb_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (i_data_in),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    // The result register holds the flags and count; the byte itself sits in
    // the storage read register, which only changes when a new read is issued.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_flags <= w_flags;
            r_occ   <= w_occ;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_out  = r_flags.rd_hit ? w_rdata : '0;
    assign o_status    = r_flags.status;
    assign o_is_empty  = r_flags.is_empty;
    assign o_is_full   = r_flags.is_full;
    assign o_occupancy = r_occ;

    `ASSERT_RST(a_accept_gives_result, i_clk, i_rst_n, w_acc |=> o_valid)
    `ASSERT_RST(a_empty_matches_count, i_clk, i_rst_n,
        o_valid |-> (o_is_empty == (o_occupancy == '0)))

endmodule

`default_nettype wire
